// File: rtl/vrsp_pkg.sv
// ----------------------------------------------------------------------------
// vrsp_pkg
// Shared constants, register codes, result type and arithmetic helpers for
// the vertex rotate, scale and project block.
// ----------------------------------------------------------------------------
package vrsp_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int TRIG_W         = 16;
  localparam int OUT_W          = 32;

  // CORDIC datapath sizes
  localparam int CORDIC_STEPS   = 18;
  localparam int STEP_W         = 5;
  localparam int CX_W           = 33;
  localparam int CZ_W           = 21;

  localparam logic signed [CX_W-1:0]   CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE    = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] TRIG_ZERO   = 16'sd0;

  localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 16'd4096;
  localparam logic [CFG_DATA_W-1:0] DIST_RESET  = 16'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ANGLE_X  = 3'd0,
    REG_ANGLE_Y  = 3'd1,
    REG_ANGLE_Z  = 3'd2,
    REG_SCALE_X  = 3'd3,
    REG_SCALE_Y  = 3'd4,
    REG_SCALE_Z  = 3'd5,
    REG_DISTANCE = 3'd6,
    REG_PERSP_EN = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic signed [OUT_W-1:0] depth;
    logic                    behind_viewer;
  } res_t;

  // Arctangent of 2^-i in units of 2^-20 turn
  function automatic logic [CZ_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic [CZ_W-1:0] a;
    unique case (i)
      5'd0:    a = 21'd131072;
      5'd1:    a = 21'd77376;
      5'd2:    a = 21'd40884;
      5'd3:    a = 21'd20753;
      5'd4:    a = 21'd10417;
      5'd5:    a = 21'd5213;
      5'd6:    a = 21'd2607;
      5'd7:    a = 21'd1304;
      5'd8:    a = 21'd652;
      5'd9:    a = 21'd326;
      5'd10:   a = 21'd163;
      5'd11:   a = 21'd81;
      5'd12:   a = 21'd41;
      5'd13:   a = 21'd20;
      5'd14:   a = 21'd10;
      5'd15:   a = 21'd5;
      5'd16:   a = 21'd3;
      5'd17:   a = 21'd1;
      default: a = 21'd0;
    endcase
    return a;
  endfunction

  // Clamp a rounded CORDIC output to the unit range
  function automatic logic signed [TRIG_W-1:0] clamp_q14(input logic signed [17:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > 18'sd16384) begin
      r = TRIG_ONE;
    end else if (v < -18'sd16384) begin
      r = -TRIG_ONE;
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

  // Saturate a signed value to 32 bits
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  // Apply a sign to an unsigned magnitude and saturate to 32 bits
  function automatic logic signed [OUT_W-1:0] sat_mag(input logic [63:0] mag,
                                                      input logic        neg);
    logic signed [OUT_W-1:0] r;
    if (neg) begin
      r = (mag > 64'd2147483648) ? 32'sh80000000 : -$signed(mag[OUT_W-1:0]);
    end else begin
      r = (mag > 64'd2147483647) ? 32'sh7fffffff : $signed(mag[OUT_W-1:0]);
    end
    return r;
  endfunction

endpackage

// File: rtl/vrsp_if.sv
// ----------------------------------------------------------------------------
// vrsp channel interfaces
// Valid/ready channels for vertex items, result items and register writes.
// ----------------------------------------------------------------------------
interface vrsp_in_if #(
  parameter int COORD_BITS = vrsp_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;

  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface vrsp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vrsp_pkg::OUT_W-1:0]  screen_x;
  logic signed [vrsp_pkg::OUT_W-1:0]  screen_y;
  logic signed [vrsp_pkg::OUT_W-1:0]  depth;
  logic                               behind_viewer;

  modport source (output valid, screen_x, screen_y, depth, behind_viewer, input ready);
  modport sink   (input valid, screen_x, screen_y, depth, behind_viewer, output ready);
endinterface

interface vrsp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vrsp_pkg::CFG_ADDR_W-1:0]  addr;
  logic [vrsp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/vertex_rotate_scale_project_top.sv
// ----------------------------------------------------------------------------
// vertex_rotate_scale_project_top
// Rotates a vertex about x, y and z, scales each axis and optionally applies
// a perspective divide; sine/cosine pairs come from a shared CORDIC unit.
// ----------------------------------------------------------------------------
// Throughput: one vertex per cycle while the CORDIC is idle and the skid
//   entry is free; the restoring divider is fully pipelined, one quotient
//   bit per stage, so its depth sets most of the latency. An angle write runs
//   the CORDIC iterations and then stores the pair; vertex and config ready
//   stay low meanwhile. Reset is synchronous: pipeline empties, registers take
//   their defaults and all sine/cosine pairs become those of angle zero.
// ----------------------------------------------------------------------------
module vertex_rotate_scale_project_top #(
  parameter int COORD_BITS = vrsp_pkg::COORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  vrsp_in_if.sink         vertex,
  vrsp_out_if.source      result,
  vrsp_cfg_if.sink        cfg
);

  // Datapath widths, all signed unless noted
  localparam int V0    = COORD_BITS + 4;          // Q4 input
  localparam int R1W   = V0 + 1;                  // after x rotation
  localparam int X2W   = V0 + 2;                  // after y rotation
  localparam int X3W   = V0 + 3;                  // after z rotation
  localparam int P1W   = vrsp_pkg::TRIG_W + V0;
  localparam int P2W   = vrsp_pkg::TRIG_W + R1W;
  localparam int P3W   = vrsp_pkg::TRIG_W + X2W;
  localparam int SCW   = X3W + 17;
  localparam int X4W   = X3W + 4;
  localparam int Z4W   = X2W + 4;
  localparam int DEN_W = ((Z4W > 21) ? Z4W : 21) + 1;
  localparam int DUW   = DEN_W - 1;               // positive denominator, unsigned
  localparam int PW    = X4W + 21;
  localparam int NUM_W = PW;                      // dividend, unsigned

  localparam int TW = vrsp_pkg::TRIG_W;
  localparam int OW = vrsp_pkg::OUT_W;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_RUN  = 3'b010,
    CS_FIN  = 3'b100
  } cordic_state_t;

  typedef struct packed {
    logic                 use_div;
    logic                 behind;
    logic signed [OW-1:0] ox;
    logic signed [OW-1:0] oy;
    logic signed [OW-1:0] oz;
  } side_t;

  // --------------------------------------------------------------------------
  // Configuration registers and CORDIC sequencer
  // --------------------------------------------------------------------------
  logic [vrsp_pkg::CFG_DATA_W-1:0] scale_x, scale_y, scale_z, persp_distance;
  logic                            persp_enable;

  cordic_state_t                    cst;
  logic signed [vrsp_pkg::CX_W-1:0] cx, cy;
  logic signed [vrsp_pkg::CZ_W-1:0] cz;
  logic [vrsp_pkg::STEP_W-1:0]      step;
  logic [1:0]                       sel;
  logic [1:0]                       quad;
  logic signed [TW-1:0]             cos_q [3];
  logic signed [TW-1:0]             sin_q [3];

  logic                             cfg_wr;
  vrsp_pkg::cfg_reg_t               cfg_reg;
  logic signed [vrsp_pkg::CX_W-1:0] cx_sh, cy_sh;
  logic signed [vrsp_pkg::CZ_W-1:0] cz_at;
  logic signed [vrsp_pkg::CX_W:0]   c_sum, s_sum, c_rnd, s_rnd;
  logic signed [TW-1:0]             c_cl, s_cl, c_map, s_map;

  assign cfg.ready = (cst == CS_IDLE);
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign cfg_reg   = vrsp_pkg::cfg_reg_t'(cfg.addr);

  // One micro-rotation and the final rounding and quadrant fold
  always_comb begin
    cx_sh = cx >>> step;
    cy_sh = cy >>> step;
    cz_at = $signed(vrsp_pkg::atan_step(step));
    c_sum = (vrsp_pkg::CX_W+1)'(cx) + (vrsp_pkg::CX_W+1)'(32768);
    s_sum = (vrsp_pkg::CX_W+1)'(cy) + (vrsp_pkg::CX_W+1)'(32768);
    c_rnd = c_sum >>> 16;
    s_rnd = s_sum >>> 16;
    c_cl  = vrsp_pkg::clamp_q14(c_rnd[17:0]);
    s_cl  = vrsp_pkg::clamp_q14(s_rnd[17:0]);
    unique case (quad)
      2'd0: begin c_map = c_cl;  s_map = s_cl;  end
      2'd1: begin c_map = -s_cl; s_map = c_cl;  end
      2'd2: begin c_map = -c_cl; s_map = -s_cl; end
      2'd3: begin c_map = s_cl;  s_map = -c_cl; end
    endcase
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x        <= vrsp_pkg::SCALE_RESET;
      scale_y        <= vrsp_pkg::SCALE_RESET;
      scale_z        <= vrsp_pkg::SCALE_RESET;
      persp_distance <= vrsp_pkg::DIST_RESET;
      persp_enable   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        vrsp_pkg::REG_ANGLE_X,
        vrsp_pkg::REG_ANGLE_Y,
        vrsp_pkg::REG_ANGLE_Z:  ;
        vrsp_pkg::REG_SCALE_X:  scale_x        <= cfg.data;
        vrsp_pkg::REG_SCALE_Y:  scale_y        <= cfg.data;
        vrsp_pkg::REG_SCALE_Z:  scale_z        <= cfg.data;
        vrsp_pkg::REG_DISTANCE: persp_distance <= cfg.data;
        vrsp_pkg::REG_PERSP_EN: persp_enable   <= cfg.data[0];
      endcase
    end
  end

  // CORDIC sequencer: start on an angle write, iterate, then store the pair
  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= CS_IDLE;
      for (int i = 0; i < 3; i++) begin
        cos_q[i] <= vrsp_pkg::TRIG_ONE;
        sin_q[i] <= vrsp_pkg::TRIG_ZERO;
      end
    end else begin
      unique case (cst)
        CS_IDLE: begin
          if (cfg_wr && (cfg_reg == vrsp_pkg::REG_ANGLE_X ||
                         cfg_reg == vrsp_pkg::REG_ANGLE_Y ||
                         cfg_reg == vrsp_pkg::REG_ANGLE_Z)) begin
            cst  <= CS_RUN;
            sel  <= cfg.addr[1:0];
            quad <= cfg.data[15:14];
            cx   <= vrsp_pkg::CORDIC_GAIN;
            cy   <= '0;
            cz   <= $signed({3'b000, cfg.data[13:0], 4'b0000});
            step <= '0;
          end
        end
        CS_RUN: begin
          if (cz >= 0) begin
            cx <= cx - cy_sh;
            cy <= cy + cx_sh;
            cz <= cz - cz_at;
          end else begin
            cx <= cx + cy_sh;
            cy <= cy - cx_sh;
            cz <= cz + cz_at;
          end
          if (step == vrsp_pkg::STEP_W'(vrsp_pkg::CORDIC_STEPS - 1)) begin
            cst <= CS_FIN;
          end
          step <= step + 1'b1;
        end
        CS_FIN: begin
          cos_q[sel] <= c_map;
          sin_q[sel] <= s_map;
          cst        <= CS_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: global advance while the skid entry is free
  // --------------------------------------------------------------------------
  logic              en, acc;
  logic [9:1]        vld;
  logic              dv_v [NUM_W+1];
  logic              out_v, skid_v;
  vrsp_pkg::res_t    out_r, skid_r, fin;

  assign en           = !skid_v;
  assign vertex.ready = en && (cst == CS_IDLE);
  assign acc          = vertex.valid && vertex.ready;

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      dv_v[0]  <= 1'b0;
    end else if (en) begin
      vld[1]   <= acc;
      for (int k = 2; k <= 9; k++) begin
        vld[k] <= vld[k-1];
      end
      dv_v[0]  <= vld[9];
    end
  end

  // --------------------------------------------------------------------------
  // Rotation about x
  // --------------------------------------------------------------------------
  logic signed [V0-1:0]  x_in, y_in, z_in;
  logic signed [P1W-1:0] p1_cy, p1_sz, p1_sy, p1_cz;
  logic signed [V0-1:0]  x1;
  logic signed [P1W:0]   s2_a, s2_b, s2_ar, s2_br;
  logic signed [R1W-1:0] y2, z2r;
  logic signed [V0-1:0]  x2c;

  assign x_in = {vertex.vertex_x, 4'b0000};
  assign y_in = {vertex.vertex_y, 4'b0000};
  assign z_in = {vertex.vertex_z, 4'b0000};

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      p1_cy <= cos_q[0] * y_in;
      p1_sz <= sin_q[0] * z_in;
      p1_sy <= sin_q[0] * y_in;
      p1_cz <= cos_q[0] * z_in;
      x1    <= x_in;
    end
  end

  always_comb begin
    s2_a  = (P1W+1)'(p1_cy) - (P1W+1)'(p1_sz) + (P1W+1)'(8192);
    s2_b  = (P1W+1)'(p1_sy) + (P1W+1)'(p1_cz) + (P1W+1)'(8192);
    s2_ar = s2_a >>> 14;
    s2_br = s2_b >>> 14;
  end

  // Stage 2: round back to Q4
  always_ff @(posedge clk) begin
    if (en) begin
      y2  <= s2_ar[R1W-1:0];
      z2r <= s2_br[R1W-1:0];
      x2c <= x1;
    end
  end

  // --------------------------------------------------------------------------
  // Rotation about y
  // --------------------------------------------------------------------------
  logic signed [P2W-1:0] p3_cx, p3_sz, p3_cz, p3_sx;
  logic signed [R1W-1:0] y3c;
  logic signed [P2W:0]   s4_a, s4_b, s4_ar, s4_br;
  logic signed [X2W-1:0] x4r, z4r;
  logic signed [R1W-1:0] y4c;

  // Stage 3: products
  always_ff @(posedge clk) begin
    if (en) begin
      p3_cx <= cos_q[1] * x2c;
      p3_sz <= sin_q[1] * z2r;
      p3_cz <= cos_q[1] * z2r;
      p3_sx <= sin_q[1] * x2c;
      y3c   <= y2;
    end
  end

  always_comb begin
    s4_a  = (P2W+1)'(p3_cx) + (P2W+1)'(p3_sz) + (P2W+1)'(8192);
    s4_b  = (P2W+1)'(p3_cz) - (P2W+1)'(p3_sx) + (P2W+1)'(8192);
    s4_ar = s4_a >>> 14;
    s4_br = s4_b >>> 14;
  end

  // Stage 4: round back to Q4
  always_ff @(posedge clk) begin
    if (en) begin
      x4r <= s4_ar[X2W-1:0];
      z4r <= s4_br[X2W-1:0];
      y4c <= y3c;
    end
  end

  // --------------------------------------------------------------------------
  // Rotation about z
  // --------------------------------------------------------------------------
  logic signed [P3W-1:0] p5_cx, p5_sy, p5_sx, p5_cy;
  logic signed [X2W-1:0] z5c;
  logic signed [P3W:0]   s6_a, s6_b, s6_ar, s6_br;
  logic signed [X3W-1:0] x6, y6;
  logic signed [X2W-1:0] z6c;

  // Stage 5: products
  always_ff @(posedge clk) begin
    if (en) begin
      p5_cx <= cos_q[2] * x4r;
      p5_sy <= sin_q[2] * y4c;
      p5_sx <= sin_q[2] * x4r;
      p5_cy <= cos_q[2] * y4c;
      z5c   <= z4r;
    end
  end

  always_comb begin
    s6_a  = (P3W+1)'(p5_cx) - (P3W+1)'(p5_sy) + (P3W+1)'(8192);
    s6_b  = (P3W+1)'(p5_sx) + (P3W+1)'(p5_cy) + (P3W+1)'(8192);
    s6_ar = s6_a >>> 14;
    s6_br = s6_b >>> 14;
  end

  // Stage 6: round back to Q4
  always_ff @(posedge clk) begin
    if (en) begin
      x6  <= s6_ar[X3W-1:0];
      y6  <= s6_br[X3W-1:0];
      z6c <= z5c;
    end
  end

  // --------------------------------------------------------------------------
  // Per-axis scale, denominator and orthographic results
  // --------------------------------------------------------------------------
  logic signed [SCW-1:0]   q7x, q7y, q7z;
  logic signed [SCW-1:0]   t8x, t8y, t8z;
  logic signed [X4W-1:0]   x8n, y8n;
  logic signed [Z4W-1:0]   z8n;
  logic [19:0]             dq4;
  logic signed [DEN_W-1:0] den8n;
  logic                    behind8n;
  logic signed [X4W-1:0]   x8, y8;
  logic signed [DEN_W-1:0] den8;
  side_t                   side8;

  // Stage 7: scale products
  always_ff @(posedge clk) begin
    if (en) begin
      q7x <= x6  * $signed({1'b0, scale_x});
      q7y <= y6  * $signed({1'b0, scale_y});
      q7z <= z6c * $signed({1'b0, scale_z});
    end
  end

  assign dq4 = {persp_distance, 4'b0000};

  always_comb begin
    t8x      = (q7x + SCW'(2048)) >>> 12;
    t8y      = (q7y + SCW'(2048)) >>> 12;
    t8z      = (q7z + SCW'(2048)) >>> 12;
    x8n      = t8x[X4W-1:0];
    y8n      = t8y[X4W-1:0];
    z8n      = t8z[Z4W-1:0];
    den8n    = DEN_W'($signed({1'b0, dq4})) - DEN_W'(z8n);
    behind8n = persp_enable && (den8n[DEN_W-1] || (den8n == '0));
  end

  // Stage 8: round, form denominator, saturate the pass-through values
  always_ff @(posedge clk) begin
    if (en) begin
      x8            <= x8n;
      y8            <= y8n;
      den8          <= den8n;
      side8.use_div <= persp_enable && !behind8n;
      side8.behind  <= behind8n;
      side8.ox      <= vrsp_pkg::sat32(64'(x8n));
      side8.oy      <= vrsp_pkg::sat32(64'(y8n));
      side8.oz      <= vrsp_pkg::sat32(64'(z8n));
    end
  end

  // --------------------------------------------------------------------------
  // Perspective numerator
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] p9x, p9y;
  logic [DUW-1:0]       den9;
  side_t                side9;
  logic [NUM_W-1:0]     mag_x, mag_y;

  // Stage 9: numerator products
  always_ff @(posedge clk) begin
    if (en) begin
      p9x   <= x8 * $signed({1'b0, dq4});
      p9y   <= y8 * $signed({1'b0, dq4});
      den9  <= den8[DUW-1:0];
      side9 <= side8;
    end
  end

  always_comb begin
    mag_x = p9x[PW-1] ? NUM_W'(-p9x) : NUM_W'(p9x);
    mag_y = p9y[PW-1] ? NUM_W'(-p9y) : NUM_W'(p9y);
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, x and y lanes
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0] dnumx [NUM_W+1];
  logic [NUM_W-1:0] dnumy [NUM_W+1];
  logic [DUW-1:0]   dremx [NUM_W+1];
  logic [DUW-1:0]   dremy [NUM_W+1];
  logic [NUM_W-1:0] dquox [NUM_W+1];
  logic [NUM_W-1:0] dquoy [NUM_W+1];
  logic [DUW-1:0]   dden  [NUM_W+1];
  logic             dnegx [NUM_W+1];
  logic             dnegy [NUM_W+1];
  side_t            dside [NUM_W+1];

  // Stage 10: add half the denominator for rounding, load divider
  always_ff @(posedge clk) begin
    if (en) begin
      dnumx[0] <= mag_x + NUM_W'(den9 >> 1);
      dnumy[0] <= mag_y + NUM_W'(den9 >> 1);
      dremx[0] <= '0;
      dremy[0] <= '0;
      dquox[0] <= '0;
      dquoy[0] <= '0;
      dden[0]  <= den9;
      dnegx[0] <= p9x[PW-1];
      dnegy[0] <= p9y[PW-1];
      dside[0] <= side9;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [DUW:0]   catx, caty;
    logic           gex, gey;
    logic [DUW-1:0] remx_n, remy_n;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
      catx   = {dremx[k], dnumx[k][NUM_W-1]};
      caty   = {dremy[k], dnumy[k][NUM_W-1]};
      gex    = (catx >= {1'b0, dden[k]});
      gey    = (caty >= {1'b0, dden[k]});
      remx_n = gex ? DUW'(catx - {1'b0, dden[k]}) : catx[DUW-1:0];
      remy_n = gey ? DUW'(caty - {1'b0, dden[k]}) : caty[DUW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dnumx[k+1] <= dnumx[k] << 1;
        dnumy[k+1] <= dnumy[k] << 1;
        dremx[k+1] <= remx_n;
        dremy[k+1] <= remy_n;
        dquox[k+1] <= {dquox[k][NUM_W-2:0], gex};
        dquoy[k+1] <= {dquoy[k][NUM_W-2:0], gey};
        dden[k+1]  <= dden[k];
        dnegx[k+1] <= dnegx[k];
        dnegy[k+1] <= dnegy[k];
        dside[k+1] <= dside[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result select and output register with skid entry
  // --------------------------------------------------------------------------
  always_comb begin
    fin.depth         = dside[NUM_W].oz;
    fin.behind_viewer = dside[NUM_W].behind;
    if (dside[NUM_W].use_div) begin
      fin.screen_x = vrsp_pkg::sat_mag(64'(dquox[NUM_W]), dnegx[NUM_W]);
      fin.screen_y = vrsp_pkg::sat_mag(64'(dquoy[NUM_W]), dnegy[NUM_W]);
    end else if (dside[NUM_W].behind) begin
      fin.screen_x = '0;
      fin.screen_y = '0;
    end else begin
      fin.screen_x = dside[NUM_W].ox;
      fin.screen_y = dside[NUM_W].oy;
    end
  end

  // Hold, refill from skid, or load from the last stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (result.ready) begin
        out_r  <= skid_r;
        skid_v <= 1'b0;
      end
    end else if (dv_v[NUM_W]) begin
      if (!out_v || result.ready) begin
        out_r <= fin;
        out_v <= 1'b1;
      end else begin
        skid_r <= fin;
        skid_v <= 1'b1;
      end
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  assign result.valid         = out_v;
  assign result.screen_x      = out_r.screen_x;
  assign result.screen_y      = out_r.screen_y;
  assign result.depth         = out_r.depth;
  assign result.behind_viewer = out_r.behind_viewer;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (cst != CS_IDLE) |-> (!vertex.ready && !cfg.ready))
    else $error("item or write accepted while CORDIC busy");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry held without output item");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_v && !result.ready && dv_v[NUM_W] && !skid_v) |=> skid_v)
    else $error("stalled result not caught by skid entry");

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.behind_viewer) |->
      (result.screen_x == '0 && result.screen_y == '0))
    else $error("behind-viewer item with nonzero screen position");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (cst == CS_RUN) |-> (step < vrsp_pkg::STEP_W'(vrsp_pkg::CORDIC_STEPS)))
    else $error("CORDIC step counter overran");

endmodule
